@@ sv/bpfa_pkg.sv @@
// Types and constants shared by the bitmap page frame allocator.
package bpfa_pkg;

    localparam int ADDR_W     = 28;
    localparam int PAGE_SHIFT = 12;
    localparam int RUN_W      = 7;
    localparam int KB_W       = 19;
    localparam int CFG_W      = 17;
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 3;

    localparam logic [CFG_W-1:0] FLOOR_RESET = CFG_W'(512);
    localparam logic [CFG_W-1:0] CFG_MAX     = '1;

    localparam logic [1:0] ACT_MARK_FREE = 2'd0;
    localparam logic [1:0] ACT_MARK_USED = 2'd1;
    localparam logic [1:0] ACT_ALLOC_ONE = 2'd2;
    localparam logic [1:0] ACT_ALLOC_RUN = 2'd3;

    localparam logic REG_TOTAL = 1'b0;
    localparam logic REG_FLOOR = 1'b1;

    typedef struct packed {
        logic [1:0]        action;
        logic [ADDR_W-1:0] phys_address;
        logic [RUN_W-1:0]  run_length;
    } in_item_t;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] alloc_address;
        logic [KB_W-1:0]   used_kb;
        logic [KB_W-1:0]   free_kb;
    } out_item_t;

endpackage

@@ sv/bitmap_page_frame_allocator.sv @@
// Bitmap page frame allocator: frame map memory, first fit scan and result register.
//
// Usage: s_valid/s_ready carry one request beat (mark free, mark used, allocate one
// frame, allocate a run); m_valid/m_ready carry one result beat per request.
// The APB port holds total_frames (0x0) and reserved_floor (0x4); write them while idle.
// The map lives in one memory of MAP_WORD_BITS-bit words with registered read data.
// A mark runs from the accepting edge to the result register through divide, split with
// the map read issued, modify/write and done; a frame at or past total_frames skips
// modify/write. An allocation runs through divide and split, then scans map words from
// the floor word to the word where the run completes (up to MAP_WORDS), then walks
// back through each earlier word the run reaches into, then done.
// After reset, and after every write of total_frames, a fill pass writes all-ones to
// every map word, during which s_ready stays low.
// s_ready is high only when no request is in flight. A finished result waits in the
// output register; the next request is accepted meanwhile, and its result holds in the
// done state until the output register frees up.
module bitmap_page_frame_allocator #(
    parameter int MAX_FRAMES    = 65536,
    parameter int MAP_WORD_BITS = 32,
    parameter int MAX_RUN       = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  bpfa_pkg::in_item_t              s_data,

    output logic                            m_valid,
    input  logic                            m_ready,
    output bpfa_pkg::out_item_t             m_data,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bpfa_pkg::APB_AW-1:0]     paddr,
    input  logic [bpfa_pkg::APB_DW-1:0]     pwdata,
    output logic [bpfa_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);

    localparam int W         = MAP_WORD_BITS;
    localparam int MAP_WORDS = (MAX_FRAMES + W - 1) / W;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW        = $clog2(W);
    localparam int FW        = bpfa_pkg::CFG_W;
    localparam int CW        = $clog2(MAX_RUN + 1);
    localparam int SW        = $clog2(MAX_RUN + W + 1);
    localparam int DIV_SHIFT = FW + $clog2(W);
    localparam int RW        = DIV_SHIFT + 1;
    localparam logic [RW-1:0] DIV_RECIP =
        RW'(((64'd1 << DIV_SHIFT) + 64'(W) - 64'd1) / 64'(W));
    localparam logic [FW-1:0] TOTAL_RESET =
        (MAX_FRAMES > int'(bpfa_pkg::CFG_MAX)) ? bpfa_pkg::CFG_MAX : FW'(MAX_FRAMES);
    localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_CLEAR = 8'b0000_0010,
        ST_DIV   = 8'b0000_0100,
        ST_SPLIT = 8'b0000_1000,
        ST_MARK  = 8'b0001_0000,
        ST_SCAN  = 8'b0010_0000,
        ST_WB    = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [FW-1:0]    total_reg, total_next;
    logic [FW-1:0]    floor_reg, floor_next;
    logic [FW-1:0]    free_reg, free_next;
    logic [AW-1:0]    clr_reg, clr_next;

    logic [1:0]       action_reg, action_next;
    logic [FW-1:0]    frame_reg, frame_next;
    logic [bpfa_pkg::RUN_W-1:0] len_reg, len_next;

    logic [FW-1:0]    q_reg, q_next;
    logic [BW-1:0]    bit_reg, bit_next;
    logic [FW-1:0]    base_reg, base_next;
    logic [AW-1:0]    scan_w_reg, scan_w_next;
    logic [SW-1:0]    carry_reg, carry_next;
    logic [AW-1:0]    wb_w_reg, wb_w_next;
    logic [CW-1:0]    wb_rem_reg, wb_rem_next;

    logic                        res_ok_reg, res_ok_next;
    logic [bpfa_pkg::ADDR_W-1:0] res_addr_reg, res_addr_next;

    logic                m_valid_reg, m_valid_next;
    bpfa_pkg::out_item_t m_data_reg, m_data_next;

    // frame map memory
    logic [W-1:0]  map_mem [MAP_WORDS];
    logic [W-1:0]  rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [W-1:0]  wr_data;

    always_ff @(posedge aclk) begin
        rd_data_reg <= map_mem[rd_addr];
        if (wr_en) begin
            map_mem[wr_addr] <= wr_data;
        end
    end

    // divide by the word size through a reciprocal
    logic [FW-1:0]    div_in;
    logic [FW+RW-1:0] div_prod;
    logic [FW-1:0]    q_times_w;

    assign div_in    = (action_reg == bpfa_pkg::ACT_MARK_FREE ||
                        action_reg == bpfa_pkg::ACT_MARK_USED) ? frame_reg : floor_reg;
    assign div_prod  = (FW+RW)'(div_in) * (FW+RW)'(DIV_RECIP);
    assign q_times_w = FW'(q_reg * FW'(W));

    // scan of one map word
    logic signed [FW+1:0] d_lo, d_hi;
    logic [W-1:0]         free_mask;
    logic [SW-1:0]        streak [W];
    logic [W-1:0]         hit;
    logic                 hit_any;
    logic [BW-1:0]        hit_pos;
    logic [SW-1:0]        len_s;
    logic [SW-1:0]        carry_adv;
    logic                 last_word;

    assign len_s = SW'(len_reg);
    assign d_lo  = $signed({2'b00, floor_reg}) - $signed({2'b00, base_reg});
    assign d_hi  = $signed({2'b00, total_reg}) - $signed({2'b00, base_reg});
    assign last_word = ({1'b0, base_reg} + (FW+1)'(W)) >= {1'b0, total_reg};

    always_comb begin : scan_word
        int   last;
        logic found;
        for (int b = 0; b < W; b++) begin
            free_mask[b] = !rd_data_reg[b]
                && ($signed((FW+2)'(b)) >= d_lo) && ($signed((FW+2)'(b)) < d_hi);
        end
        for (int p = 0; p < W; p++) begin
            last  = 0;
            found = 1'b0;
            for (int q = 0; q < W; q++) begin
                if (q <= p && !free_mask[q]) begin
                    last  = q;
                    found = 1'b1;
                end
            end
            if (found) begin
                streak[p] = SW'(p - last);
            end else begin
                streak[p] = carry_reg + SW'(p + 1);
            end
            hit[p] = (streak[p] >= len_s);
        end
        hit_any = |hit;
        hit_pos = '0;
        for (int p = W - 1; p >= 0; p--) begin
            if (hit[p]) begin
                hit_pos = BW'(p);
            end
        end
        if (&free_mask) begin
            carry_adv = (carry_reg + SW'(W) >= SW'(MAX_RUN)) ? SW'(MAX_RUN)
                                                             : carry_reg + SW'(W);
        end else begin
            carry_adv = (streak[W-1] >= SW'(MAX_RUN)) ? SW'(MAX_RUN) : streak[W-1];
        end
    end

    // run masks for the word where the run ends and for words reached back into
    logic [W-1:0]  end_mask, back_mask;
    logic [SW-1:0] end_span;

    assign end_span = SW'(hit_pos) + SW'(1);

    always_comb begin
        for (int b = 0; b < W; b++) begin
            end_mask[b]  = (b <= int'(hit_pos)) && (b + int'(len_reg) > int'(hit_pos));
            back_mask[b] = (b + int'(wb_rem_reg) >= W);
        end
    end

    logic cfg_wr;
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == bpfa_pkg::REG_FLOOR) ? bpfa_pkg::APB_DW'(floor_reg)
                                                       : bpfa_pkg::APB_DW'(total_reg);
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next    = state_reg;
        total_next    = total_reg;
        floor_next    = floor_reg;
        free_next     = free_reg;
        clr_next      = clr_reg;
        action_next   = action_reg;
        frame_next    = frame_reg;
        len_next      = len_reg;
        q_next        = q_reg;
        bit_next      = bit_reg;
        base_next     = base_reg;
        scan_w_next   = scan_w_reg;
        carry_next    = carry_reg;
        wb_w_next     = wb_w_reg;
        wb_rem_next   = wb_rem_reg;
        res_ok_next   = res_ok_reg;
        res_addr_next = res_addr_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        rd_addr       = q_reg[AW-1:0];
        wr_en         = 1'b0;
        wr_addr       = clr_reg;
        wr_data       = '1;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    action_next = s_data.action;
                    frame_next  = FW'(s_data.phys_address[bpfa_pkg::ADDR_W-1:
                                                          bpfa_pkg::PAGE_SHIFT]);
                    len_next    = (s_data.action == bpfa_pkg::ACT_ALLOC_ONE)
                                  ? bpfa_pkg::RUN_W'(1) : s_data.run_length;
                    state_next  = ST_DIV;
                end
            end
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = '1;
                if (clr_reg == LAST_WORD) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            ST_DIV: begin
                q_next     = FW'(div_prod >> DIV_SHIFT);
                state_next = ST_SPLIT;
            end
            ST_SPLIT: begin
                // read of word q is in flight for the next state
                bit_next      = BW'(div_in - q_times_w);
                base_next     = q_times_w;
                scan_w_next   = q_reg[AW-1:0];
                carry_next    = '0;
                res_ok_next   = 1'b0;
                res_addr_next = '0;
                if (action_reg == bpfa_pkg::ACT_MARK_FREE ||
                    action_reg == bpfa_pkg::ACT_MARK_USED) begin
                    state_next = (frame_reg < total_reg) ? ST_MARK : ST_DONE;
                end else if (len_reg == '0 || 32'(len_reg) > 32'(MAX_RUN) ||
                             floor_reg >= total_reg) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_MARK: begin
                wr_en       = 1'b1;
                wr_addr     = q_reg[AW-1:0];
                wr_data     = rd_data_reg;
                res_ok_next = 1'b1;
                if (action_reg == bpfa_pkg::ACT_MARK_FREE) begin
                    wr_data[bit_reg] = 1'b0;
                    if (rd_data_reg[bit_reg]) begin
                        free_next = free_reg + FW'(1);
                    end
                end else begin
                    wr_data[bit_reg] = 1'b1;
                    if (!rd_data_reg[bit_reg]) begin
                        free_next = free_reg - FW'(1);
                    end
                end
                state_next = ST_DONE;
            end
            ST_SCAN: begin
                rd_addr = scan_w_reg + AW'(1);
                if (hit_any) begin
                    // claim the run; walk back into earlier words if it started there
                    wr_en         = 1'b1;
                    wr_addr       = scan_w_reg;
                    wr_data       = rd_data_reg | end_mask;
                    free_next     = free_reg - FW'(len_reg);
                    res_ok_next   = 1'b1;
                    res_addr_next = {base_reg[bpfa_pkg::ADDR_W-bpfa_pkg::PAGE_SHIFT-1:0]
                                     + (bpfa_pkg::ADDR_W-bpfa_pkg::PAGE_SHIFT)'(hit_pos)
                                     + (bpfa_pkg::ADDR_W-bpfa_pkg::PAGE_SHIFT)'(1)
                                     - (bpfa_pkg::ADDR_W-bpfa_pkg::PAGE_SHIFT)'(len_reg),
                                     bpfa_pkg::PAGE_SHIFT'(0)};
                    if (len_s > end_span) begin
                        rd_addr     = scan_w_reg - AW'(1);
                        wb_w_next   = scan_w_reg - AW'(1);
                        wb_rem_next = CW'(len_s - end_span);
                        state_next  = ST_WB;
                    end else begin
                        state_next = ST_DONE;
                    end
                end else if (last_word) begin
                    state_next = ST_DONE;
                end else begin
                    scan_w_next = scan_w_reg + AW'(1);
                    base_next   = base_reg + FW'(W);
                    carry_next  = carry_adv;
                end
            end
            ST_WB: begin
                wr_en   = 1'b1;
                wr_addr = wb_w_reg;
                wr_data = rd_data_reg | back_mask;
                rd_addr = wb_w_reg - AW'(1);
                if (32'(wb_rem_reg) > 32'(W)) begin
                    wb_w_next   = wb_w_reg - AW'(1);
                    wb_rem_next = wb_rem_reg - CW'(W);
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold the result until the output register frees up
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.ok            = res_ok_reg;
                    m_data_next.alloc_address = res_addr_reg;
                    m_data_next.used_kb       = {total_reg - free_reg, 2'b00};
                    m_data_next.free_kb       = {free_reg, 2'b00};
                    state_next                = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr) begin
            if (paddr[2] == bpfa_pkg::REG_FLOOR) begin
                floor_next = pwdata[FW-1:0];
            end else begin
                total_next = (32'(pwdata[FW-1:0]) > 32'(MAX_FRAMES)) ? TOTAL_RESET
                                                                     : pwdata[FW-1:0];
                free_next  = '0;
                clr_next   = '0;
                state_next = ST_CLEAR;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            total_reg   <= TOTAL_RESET;
            floor_reg   <= bpfa_pkg::FLOOR_RESET;
            free_reg    <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            floor_reg   <= floor_next;
            free_reg    <= free_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        action_reg   <= action_next;
        frame_reg    <= frame_next;
        len_reg      <= len_next;
        q_reg        <= q_next;
        bit_reg      <= bit_next;
        base_reg     <= base_next;
        scan_w_reg   <= scan_w_next;
        carry_reg    <= carry_next;
        wb_w_reg     <= wb_w_next;
        wb_rem_reg   <= wb_rem_next;
        res_ok_reg   <= res_ok_next;
        res_addr_reg <= res_addr_next;
        m_data_reg   <= m_data_next;
    end

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the bitmap page frame allocator: request, result and APB.
`timescale 1ns / 100ps

module tb;

    localparam int MAX_FRAMES     = 65536;
    localparam int MAP_WORD_BITS  = 32;
    localparam int MAX_RUN        = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    logic                          aclk    = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    bpfa_pkg::in_item_t            s_data  = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    bpfa_pkg::out_item_t           m_data;
    logic                          psel    = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite  = 1'b0;
    logic [bpfa_pkg::APB_AW-1:0]   paddr   = '0;
    logic [bpfa_pkg::APB_DW-1:0]   pwdata  = '0;
    logic [bpfa_pkg::APB_DW-1:0]   prdata;
    logic                          pready;

    // mirror of the allocator: 1 = frame used
    bit                  frame_used_map [MAX_FRAMES];
    int unsigned         free_count;
    int unsigned         total_cfg;
    int unsigned         floor_cfg;

    bpfa_pkg::in_item_t  pending_reqs [$];
    bpfa_pkg::out_item_t expected_results [$];
    int unsigned         send_idle_pct = 0;
    int unsigned         stall_pct     = 0;
    int unsigned         sink_hold     = 0;
    int unsigned         stall_cycles  = 0;
    int unsigned         mismatch_count = 0;
    logic                req_taken     = 1'b0;

    bitmap_page_frame_allocator #(
        .MAX_FRAMES    (MAX_FRAMES),
        .MAP_WORD_BITS (MAP_WORD_BITS),
        .MAX_RUN       (MAX_RUN)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void map_reinit();
        foreach (frame_used_map[i]) frame_used_map[i] = 1'b1;
        free_count = 0;
    endfunction

    // Apply one request to the mirror and return the result it must produce.
    function automatic bpfa_pkg::out_item_t serve_request(bpfa_pkg::in_item_t req);
        bpfa_pkg::out_item_t res;
        int unsigned frame;
        int unsigned len;
        int unsigned run;
        int unsigned first;
        int unsigned f;
        bit          found;
        res   = '0;
        frame = 32'(req.phys_address[bpfa_pkg::ADDR_W-1:bpfa_pkg::PAGE_SHIFT]);
        first = 0;
        found = 1'b0;
        case (req.action) inside
            bpfa_pkg::ACT_MARK_FREE, bpfa_pkg::ACT_MARK_USED: begin
                if (frame < total_cfg) begin
                    res.ok = 1'b1;
                    if (req.action == bpfa_pkg::ACT_MARK_FREE && frame_used_map[frame]) begin
                        frame_used_map[frame] = 1'b0;
                        free_count++;
                    end else if (req.action == bpfa_pkg::ACT_MARK_USED &&
                                 !frame_used_map[frame]) begin
                        frame_used_map[frame] = 1'b1;
                        free_count--;
                    end
                end
            end
            default: begin
                len = (req.action == bpfa_pkg::ACT_ALLOC_ONE) ? 1 : 32'(req.run_length);
                if (len >= 1 && len <= MAX_RUN) begin
                    run = 0;
                    // first fit from the floor
                    for (f = floor_cfg; f < total_cfg && !found; f++) begin
                        if (frame_used_map[f]) begin
                            run = 0;
                        end else begin
                            run++;
                            if (run == len) begin
                                first = f + 1 - len;
                                found = 1'b1;
                            end
                        end
                    end
                end
                if (found) begin
                    for (f = first; f < first + len; f++) frame_used_map[f] = 1'b1;
                    free_count -= len;
                    res.ok = 1'b1;
                    res.alloc_address = bpfa_pkg::ADDR_W'(first << bpfa_pkg::PAGE_SHIFT);
                end
            end
        endcase
        res.used_kb = bpfa_pkg::KB_W'((total_cfg - free_count) * 4);
        res.free_kb = bpfa_pkg::KB_W'(free_count * 4);
        return res;
    endfunction

    function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatch_count++;
        end
    endfunction

    // request driver: advance to the next queued beat once the current one is taken
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || req_taken) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_data  <= pending_reqs.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result sink: hold off for sink_hold cycles when asked, else stall at random
    always @(negedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // monitor: predict on request beats, check result beats, watch for a hang
    always @(posedge aclk) begin
        if (!aresetn) begin
            req_taken    <= 1'b0;
            stall_cycles <= 0;
        end else begin
            req_taken <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no request outstanding: %p", m_data);
                    mismatch_count++;
                end else begin
                    bpfa_pkg::out_item_t want;
                    want = expected_results.pop_front();
                    compare_field("ok", 32'(want.ok), 32'(m_data.ok));
                    compare_field("alloc_address", 32'(want.alloc_address),
                                  32'(m_data.alloc_address));
                    compare_field("used_kb", 32'(want.used_kb), 32'(m_data.used_kb));
                    compare_field("free_kb", 32'(want.free_kb), 32'(m_data.free_kb));
                end
            end
            if (s_valid && s_ready)
                expected_results.push_back(serve_request(s_data));
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("bitmap_page_frame_allocator test failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic cfg_write(logic reg_sel, logic [bpfa_pkg::CFG_W-1:0] value);
        int unsigned v;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= bpfa_pkg::APB_AW'({reg_sel, 2'b00});
        pwdata  <= {(bpfa_pkg::APB_DW - bpfa_pkg::CFG_W)'($urandom), value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        v = 32'(value);
        if (reg_sel == bpfa_pkg::REG_TOTAL) begin
            total_cfg = (v > MAX_FRAMES) ? MAX_FRAMES : v;
            map_reinit();
        end else begin
            floor_cfg = v;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic cfg_readback(logic reg_sel);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= bpfa_pkg::APB_AW'({reg_sel, 2'b00});
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (reg_sel == bpfa_pkg::REG_TOTAL)
            compare_field("total_frames readback", total_cfg, prdata);
        else
            compare_field("reserved_floor readback", floor_cfg, prdata);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_limits(logic [bpfa_pkg::CFG_W-1:0] floor_val,
                              logic [bpfa_pkg::CFG_W-1:0] total_val);
        cfg_write(bpfa_pkg::REG_FLOOR, floor_val);
        cfg_write(bpfa_pkg::REG_TOTAL, total_val);
        cfg_readback(bpfa_pkg::REG_FLOOR);
        cfg_readback(bpfa_pkg::REG_TOTAL);
    endtask

    // wait for the block to drain, then for the map fill to end
    task automatic settle();
        while (pending_reqs.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic queue_req(logic [1:0] action, logic [bpfa_pkg::ADDR_W-1:0] addr,
                             logic [bpfa_pkg::RUN_W-1:0] len);
        bpfa_pkg::in_item_t req;
        req.action       = action;
        req.phys_address = addr;
        req.run_length   = len;
        pending_reqs.push_back(req);
    endtask

    // random offset within the page; the field is don't-care for the frame number
    task automatic mark(logic [1:0] action, int unsigned frame);
        queue_req(action, {frame[15:0], 12'($urandom)}, bpfa_pkg::RUN_W'($urandom));
    endtask

    task automatic alloc_run(int unsigned len);
        queue_req(bpfa_pkg::ACT_ALLOC_RUN, bpfa_pkg::ADDR_W'($urandom),
                  bpfa_pkg::RUN_W'(len));
    endtask

    task automatic alloc_one();
        queue_req(bpfa_pkg::ACT_ALLOC_ONE, bpfa_pkg::ADDR_W'($urandom),
                  bpfa_pkg::RUN_W'($urandom));
    endtask

    function automatic int unsigned pick_frame();
        int unsigned lo;
        int unsigned hi;
        lo = (floor_cfg > 4) ? floor_cfg - 4 : 0;
        hi = total_cfg + 3;
        if (lo > hi) lo = 0;
        return $urandom_range(hi, lo);
    endfunction

    // free a contiguous span, throw in some noise, then try to allocate from it
    task automatic random_bursts(int unsigned n_items);
        int unsigned count;
        int unsigned span;
        int unsigned base;
        int unsigned k;
        count = 0;
        while (count < n_items) begin
            span = ($urandom_range(19) == 0) ? MAX_RUN : $urandom_range(10, 1);
            base = pick_frame();
            for (k = 0; k < span; k++) mark(bpfa_pkg::ACT_MARK_FREE, base + k);
            count += span;
            repeat ($urandom_range(2, 0)) begin
                case ($urandom_range(5, 0))
                    0: mark(bpfa_pkg::ACT_MARK_USED, pick_frame());
                    1: mark(bpfa_pkg::ACT_MARK_FREE, $urandom_range(MAX_FRAMES - 1, 0));
                    2: mark(bpfa_pkg::ACT_MARK_USED, $urandom_range(MAX_FRAMES - 1, 0));
                    3: alloc_run($urandom_range(1, 0) ? 0 : $urandom_range(127, MAX_RUN + 1));
                    4: alloc_one();
                    default: mark(bpfa_pkg::ACT_MARK_FREE, pick_frame());
                endcase
                count++;
            end
            repeat ($urandom_range(3, 1)) begin
                if ($urandom_range(3, 0) == 0) alloc_one();
                else alloc_run($urandom_range(span + 1, 1));
                count++;
            end
        end
    endtask

    initial begin
        total_cfg = MAX_FRAMES;
        floor_cfg = 32'(bpfa_pkg::FLOOR_RESET);
        map_reinit();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);

        // reset configuration: empty map, then top and bottom frames
        alloc_one();
        queue_req(bpfa_pkg::ACT_MARK_FREE, '1, '1);
        queue_req(bpfa_pkg::ACT_MARK_FREE, '0, '0);
        mark(bpfa_pkg::ACT_MARK_FREE, 0);
        alloc_one();
        mark(bpfa_pkg::ACT_MARK_USED, MAX_FRAMES - 1);
        mark(bpfa_pkg::ACT_MARK_USED, 0);
        for (int k = 512; k < 516; k++) mark(bpfa_pkg::ACT_MARK_FREE, k);
        alloc_run(0);
        alloc_run(MAX_RUN + 1);
        alloc_run(127);
        alloc_run(3);
        alloc_run(2);
        alloc_one();
        alloc_run(1);
        settle();

        // oversized total saturates; floor at zero
        set_limits('0, bpfa_pkg::CFG_MAX);
        mark(bpfa_pkg::ACT_MARK_FREE, 0);
        mark(bpfa_pkg::ACT_MARK_FREE, 1);
        alloc_run(2);
        settle();

        // floor equal to total: allocations fail, marks past the end are dropped
        set_limits(17'd100, 17'd100);
        mark(bpfa_pkg::ACT_MARK_FREE, 50);
        mark(bpfa_pkg::ACT_MARK_FREE, 100);
        mark(bpfa_pkg::ACT_MARK_USED, MAX_FRAMES - 1);
        alloc_one();
        alloc_run(1);
        settle();

        // no frames at all
        set_limits(bpfa_pkg::CFG_MAX, '0);
        mark(bpfa_pkg::ACT_MARK_FREE, 0);
        alloc_one();
        settle();

        // long sink hold-off with the source pushing
        set_limits(17'd16, 17'd256);
        @(posedge aclk);
        sink_hold = 400;
        random_bursts(62);
        settle();

        send_idle_pct = 59;
        stall_pct     = 0;
        set_limits('0, 17'd1000);
        random_bursts(62);
        settle();

        send_idle_pct = 0;
        stall_pct     = 59;
        set_limits(17'd200, 17'd300);
        random_bursts(62);
        settle();

        send_idle_pct = 34;
        stall_pct     = 34;
        set_limits(17'd65530, 17'h10000);
        random_bursts(62);

        while (pending_reqs.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("bitmap_page_frame_allocator test passed");
        else
            $display("bitmap_page_frame_allocator test failed");
        $finish;
    end

endmodule
